// ===== rtl/mcbs_pkg.sv =====
package mcbs_pkg;

    // Field widths
    localparam int MS_W    = 16;
    localparam int LAMP_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int SYM_MAX = 5;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 6;

    localparam int NUM_LAMPS   = 5;
    localparam int NUM_LETTERS = 26;

    // Register reset values
    localparam logic [LAMP_W-1:0] RST_LAMP       = 3'd0;
    localparam logic [MS_W-1:0]   RST_DOT_MS     = 16'd200;
    localparam logic [MS_W-1:0]   RST_DASH_MS    = 16'd600;
    localparam logic [MS_W-1:0]   RST_GAP_SYM_MS = 16'd200;
    localparam logic [MS_W-1:0]   RST_GAP_LET_MS = 16'd600;
    localparam logic [MS_W-1:0]   RST_GAP_WRD_MS = 16'd1400;

    // Register indexes (word address)
    localparam logic [2:0] REG_LAMP_SELECT   = 3'd0;
    localparam logic [2:0] REG_DOT_MS        = 3'd1;
    localparam logic [2:0] REG_DASH_MS       = 3'd2;
    localparam logic [2:0] REG_GAP_SYMBOL_MS = 3'd3;
    localparam logic [2:0] REG_GAP_LETTER_MS = 3'd4;
    localparam logic [2:0] REG_GAP_WORD_MS   = 3'd5;

    // Character codes
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LZ    = 8'h7A;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_SYM   = 2'd1,
        K_SPACE = 2'd2
    } t_kind;

    // Pattern left aligned: bit 4 is the first symbol, 1 = dash
    typedef struct packed {
        logic [CNT_W-1:0]   len;
        logic [SYM_MAX-1:0] pat;
    } t_pat;

    typedef struct packed {
        t_kind kind;
        t_pat  pat;
    } t_lookup;

    typedef struct packed {
        logic [LAMP_W-1:0] lamp_select;
        logic [MS_W-1:0]   dot_ms;
        logic [MS_W-1:0]   dash_ms;
        logic [MS_W-1:0]   gap_symbol_ms;
        logic [MS_W-1:0]   gap_letter_ms;
        logic [MS_W-1:0]   gap_word_ms;
    } t_cfg;

    // Morse table: letters A..Z then digits 0..9
    function automatic t_pat f_pattern(input logic [IDX_W-1:0] idx);
        logic [CNT_W-1:0]   len;
        logic [SYM_MAX-1:0] bits;
        t_pat               res;
        unique case (idx)
            6'd0:  begin len = 3'd2; bits = 5'd1;  end
            6'd1:  begin len = 3'd4; bits = 5'd8;  end
            6'd2:  begin len = 3'd4; bits = 5'd10; end
            6'd3:  begin len = 3'd3; bits = 5'd4;  end
            6'd4:  begin len = 3'd1; bits = 5'd0;  end
            6'd5:  begin len = 3'd4; bits = 5'd2;  end
            6'd6:  begin len = 3'd3; bits = 5'd6;  end
            6'd7:  begin len = 3'd4; bits = 5'd0;  end
            6'd8:  begin len = 3'd2; bits = 5'd0;  end
            6'd9:  begin len = 3'd4; bits = 5'd7;  end
            6'd10: begin len = 3'd3; bits = 5'd5;  end
            6'd11: begin len = 3'd4; bits = 5'd4;  end
            6'd12: begin len = 3'd2; bits = 5'd3;  end
            6'd13: begin len = 3'd2; bits = 5'd2;  end
            6'd14: begin len = 3'd3; bits = 5'd7;  end
            6'd15: begin len = 3'd4; bits = 5'd6;  end
            6'd16: begin len = 3'd4; bits = 5'd13; end
            6'd17: begin len = 3'd3; bits = 5'd2;  end
            6'd18: begin len = 3'd3; bits = 5'd0;  end
            6'd19: begin len = 3'd1; bits = 5'd1;  end
            6'd20: begin len = 3'd3; bits = 5'd1;  end
            6'd21: begin len = 3'd4; bits = 5'd1;  end
            6'd22: begin len = 3'd3; bits = 5'd3;  end
            6'd23: begin len = 3'd4; bits = 5'd9;  end
            6'd24: begin len = 3'd4; bits = 5'd11; end
            6'd25: begin len = 3'd4; bits = 5'd12; end
            6'd26: begin len = 3'd5; bits = 5'd31; end
            6'd27: begin len = 3'd5; bits = 5'd15; end
            6'd28: begin len = 3'd5; bits = 5'd7;  end
            6'd29: begin len = 3'd5; bits = 5'd3;  end
            6'd30: begin len = 3'd5; bits = 5'd1;  end
            6'd31: begin len = 3'd5; bits = 5'd0;  end
            6'd32: begin len = 3'd5; bits = 5'd16; end
            6'd33: begin len = 3'd5; bits = 5'd24; end
            6'd34: begin len = 3'd5; bits = 5'd28; end
            6'd35: begin len = 3'd5; bits = 5'd30; end
            default: begin len = 3'd1; bits = 5'd0; end
        endcase
        res.len = len;
        res.pat = SYM_MAX'(bits << (3'd5 - len));
        return res;
    endfunction

endpackage

// ===== rtl/mcbs_ifs.sv =====
interface mcbs_char_if;
    import mcbs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mcbs_desc_if;
    import mcbs_pkg::*;
    logic              valid;
    logic              ready;
    logic              lamp_on;
    logic [LAMP_W-1:0] lamp_index;
    logic [MS_W-1:0]   hold_ms;
    logic              end_of_char;

    modport source (output valid, output lamp_on, output lamp_index, output hold_ms,
                    output end_of_char, input ready);
    modport sink   (input valid, input lamp_on, input lamp_index, input hold_ms,
                    input end_of_char, output ready);
endinterface

// ===== rtl/mcbs_lookup.sv =====
module mcbs_lookup
    import mcbs_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char_code,
    output t_lookup           o_lookup
);

    logic [IDX_W-1:0] idx;

    // Classify the character and form the table index
    always_comb begin
        idx           = '0;
        o_lookup.kind = K_NONE;
        if (i_char_code == CHR_SPACE) begin
            o_lookup.kind = K_SPACE;
        end else if (i_char_code >= CHR_UA && i_char_code <= CHR_UZ) begin
            o_lookup.kind = K_SYM;
            idx           = IDX_W'(i_char_code - CHR_UA);
        end else if (i_char_code >= CHR_LA && i_char_code <= CHR_LZ) begin
            o_lookup.kind = K_SYM;
            idx           = IDX_W'(i_char_code - CHR_LA);
        end else if (i_char_code >= CHR_0 && i_char_code <= CHR_9) begin
            o_lookup.kind = K_SYM;
            idx           = IDX_W'(i_char_code - CHR_0) + IDX_W'(NUM_LETTERS);
        end
        o_lookup.pat = f_pattern(idx);
    end

endmodule

// ===== rtl/mcbs_seq.sv =====
module mcbs_seq
    import mcbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_lookup     i_lookup,
    input  t_cfg        i_cfg,
    output logic        o_idle,
    mcbs_desc_if.source o_desc
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ON     = 5'b00010,
        S_GAP    = 5'b00100,
        S_LETTER = 5'b01000,
        S_WORD   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [SYM_MAX-1:0] r_pat, n_pat;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               r_ov;
    logic               r_on;
    logic [LAMP_W-1:0]  r_lamp;
    logic [MS_W-1:0]    r_ms;
    logic               r_eoc;

    logic               can_load;
    logic               emit;
    logic               e_on;
    logic [MS_W-1:0]    e_ms;
    logic               e_eoc;

    assign can_load = !r_ov || o_desc.ready;
    assign o_idle   = (r_state == S_IDLE);

    // Symbol sequencer: one pattern bit shifted out per dot/dash
    always_comb begin
        n_state = r_state;
        n_pat   = r_pat;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        e_on    = 1'b0;
        e_ms    = i_cfg.gap_symbol_ms;
        e_eoc   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_lookup.kind)
                        K_SYM: begin
                            n_state = S_ON;
                            n_pat   = i_lookup.pat.pat;
                            n_cnt   = i_lookup.pat.len;
                        end
                        K_SPACE: n_state = S_WORD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ON: begin
                emit = can_load;
                e_on = 1'b1;
                e_ms = r_pat[SYM_MAX-1] ? i_cfg.dash_ms : i_cfg.dot_ms;
                if (can_load) n_state = S_GAP;
            end
            S_GAP: begin
                emit = can_load;
                if (can_load) begin
                    n_pat   = {r_pat[SYM_MAX-2:0], 1'b0};
                    n_cnt   = r_cnt - 1'b1;
                    n_state = (r_cnt == CNT_W'(1)) ? S_LETTER : S_ON;
                end
            end
            S_LETTER: begin
                emit  = can_load;
                e_ms  = i_cfg.gap_letter_ms;
                e_eoc = 1'b1;
                if (can_load) n_state = S_IDLE;
            end
            S_WORD: begin
                emit  = can_load;
                e_ms  = i_cfg.gap_word_ms;
                e_eoc = 1'b1;
                if (can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pat <= n_pat;
        r_cnt <= n_cnt;
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_desc.ready) begin
            r_ov <= 1'b0;
        end
        if (emit) begin
            r_on   <= e_on;
            r_lamp <= i_cfg.lamp_select;
            r_ms   <= e_ms;
            r_eoc  <= e_eoc;
        end
    end

    assign o_desc.valid       = r_ov;
    assign o_desc.lamp_on     = r_on;
    assign o_desc.lamp_index  = r_lamp;
    assign o_desc.hold_ms     = r_ms;
    assign o_desc.end_of_char = r_eoc;

endmodule

// ===== rtl/morse_code_blink_sequencer.sv =====
// Morse blink sequencer. Each accepted character word (letter of either case,
// digit or space) yields a run of lamp descriptor words on the output channel:
// per symbol a lamp-on word (dot or dash length) and a lamp-off word
// (symbol gap), then a lamp-off word of letter-gap length marked end_of_char;
// a space yields one word-gap word. Other codes, or lamp_select above 4,
// yield nothing. One descriptor word leaves per cycle when the sink is ready;
// the symbol shift register and its sequencer handle one character at a time
// and the next character is taken once it has finished. Timing and lamp
// registers sit on an APB port at byte address 4*index and should be written
// only while the block is idle.
module morse_code_blink_sequencer
    import mcbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcbs_char_if.sink   i_char,
    mcbs_desc_if.source o_desc,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_lookup    lookup;
    logic       seq_idle;
    logic       accept;
    logic       lamp_ok;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lamp_select   <= RST_LAMP;
            r_cfg.dot_ms        <= RST_DOT_MS;
            r_cfg.dash_ms       <= RST_DASH_MS;
            r_cfg.gap_symbol_ms <= RST_GAP_SYM_MS;
            r_cfg.gap_letter_ms <= RST_GAP_LET_MS;
            r_cfg.gap_word_ms   <= RST_GAP_WRD_MS;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_LAMP_SELECT:   r_cfg.lamp_select   <= pwdata[LAMP_W-1:0];
                REG_DOT_MS:        r_cfg.dot_ms        <= pwdata[MS_W-1:0];
                REG_DASH_MS:       r_cfg.dash_ms       <= pwdata[MS_W-1:0];
                REG_GAP_SYMBOL_MS: r_cfg.gap_symbol_ms <= pwdata[MS_W-1:0];
                REG_GAP_LETTER_MS: r_cfg.gap_letter_ms <= pwdata[MS_W-1:0];
                REG_GAP_WORD_MS:   r_cfg.gap_word_ms   <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_LAMP_SELECT:   prdata = 32'(r_cfg.lamp_select);
            REG_DOT_MS:        prdata = 32'(r_cfg.dot_ms);
            REG_DASH_MS:       prdata = 32'(r_cfg.dash_ms);
            REG_GAP_SYMBOL_MS: prdata = 32'(r_cfg.gap_symbol_ms);
            REG_GAP_LETTER_MS: prdata = 32'(r_cfg.gap_letter_ms);
            REG_GAP_WORD_MS:   prdata = 32'(r_cfg.gap_word_ms);
            default:           prdata = '0;
        endcase
    end

    // Input word accept
    assign i_char.ready = seq_idle;
    assign accept       = i_char.valid && seq_idle;
    assign lamp_ok      = (r_cfg.lamp_select < LAMP_W'(NUM_LAMPS));

    mcbs_lookup u_lookup (
        .i_char_code (i_char.char_code),
        .o_lookup    (lookup)
    );

    mcbs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && lamp_ok),
        .i_lookup (lookup),
        .i_cfg    (r_cfg),
        .o_idle   (seq_idle),
        .o_desc   (o_desc)
    );

endmodule

// ===== sim/morse_code_blink_sequencer_test.sv =====
module morse_code_blink_sequencer_test;
    import mcbs_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RAND_PHASES     = 6;
    localparam int RAND_PER_PHASE  = 75;

    // Register slots past the last register; writes there must be dropped
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // Morse patterns, letters A..Z then digits 0..9; symbols read from the MSB
    // of a field of the given length, 1 is a dash
    localparam int MORSE_LEN [36] = '{2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3,
                                      3, 1, 3, 4, 3, 4, 4, 4, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5};
    localparam int MORSE_BITS [36] = '{1, 8, 10, 4, 0, 2, 6, 0, 0, 7, 5, 4, 3, 2, 7, 6, 13,
                                       2, 0, 1, 1, 1, 3, 9, 11, 12, 31, 15, 7, 3, 1, 0, 16,
                                       24, 28, 30};

    typedef struct packed {
        logic              lamp_on;
        logic [LAMP_W-1:0] lamp_index;
        logic [MS_W-1:0]   hold_ms;
        logic              end_of_char;
    } t_blink_desc;

    // Tracks the lamp settings and the descriptor words each character owes
    class blink_predictor;
        logic [LAMP_W-1:0] lamp;
        logic [MS_W-1:0]   dot_len;
        logic [MS_W-1:0]   dash_len;
        logic [MS_W-1:0]   sym_gap;
        logic [MS_W-1:0]   letter_gap;
        logic [MS_W-1:0]   word_gap;
        t_blink_desc       owed_desc[$];
        int                mismatches;
        int                desc_checked;

        function new();
            lamp         = RST_LAMP;
            dot_len      = RST_DOT_MS;
            dash_len     = RST_DASH_MS;
            sym_gap      = RST_GAP_SYM_MS;
            letter_gap   = RST_GAP_LET_MS;
            word_gap     = RST_GAP_WRD_MS;
            mismatches   = 0;
            desc_checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_LAMP_SELECT:   lamp       = value[LAMP_W-1:0];
                REG_DOT_MS:        dot_len    = value[MS_W-1:0];
                REG_DASH_MS:       dash_len   = value[MS_W-1:0];
                REG_GAP_SYMBOL_MS: sym_gap    = value[MS_W-1:0];
                REG_GAP_LETTER_MS: letter_gap = value[MS_W-1:0];
                REG_GAP_WORD_MS:   word_gap   = value[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function void push(logic on, logic [MS_W-1:0] ms, logic last);
            t_blink_desc d;
            d.lamp_on     = on;
            d.lamp_index  = lamp;
            d.hold_ms     = ms;
            d.end_of_char = last;
            owed_desc.push_back(d);
        endfunction

        // Accepted character word: queue the descriptors it should produce
        function void char_taken(logic [CHAR_W-1:0] c);
            int idx;
            int len;
            int bits;
            if (lamp >= NUM_LAMPS) return;
            if (c == CHR_SPACE) begin
                push(1'b0, word_gap, 1'b1);
                return;
            end
            if (c >= CHR_UA && c <= CHR_UZ) idx = int'(c - CHR_UA);
            else if (c >= CHR_LA && c <= CHR_LZ) idx = int'(c - CHR_LA);
            else if (c >= CHR_0 && c <= CHR_9) idx = int'(c - CHR_0) + NUM_LETTERS;
            else return;
            len  = MORSE_LEN[idx];
            bits = MORSE_BITS[idx];
            for (int i = 0; i < len; i++) begin
                push(1'b1, ((bits >> (len - 1 - i)) & 1) != 0 ? dash_len : dot_len, 1'b0);
                push(1'b0, sym_gap, 1'b0);
            end
            push(1'b0, letter_gap, 1'b1);
        endfunction

        // Accepted descriptor word: compare with the oldest one owed
        function void desc_seen(t_blink_desc got);
            t_blink_desc want;
            desc_checked++;
            if (owed_desc.size() == 0) begin
                $error("descriptor with nothing owed: on=%0d lamp=%0d ms=%0d eoc=%0d",
                       got.lamp_on, got.lamp_index, got.hold_ms, got.end_of_char);
                mismatches++;
                return;
            end
            want = owed_desc.pop_front();
            if (got.lamp_on !== want.lamp_on) begin
                $error("lamp_on: expected %0d, got %0d", want.lamp_on, got.lamp_on);
                mismatches++;
            end
            if (got.lamp_index !== want.lamp_index) begin
                $error("lamp_index: expected %0d, got %0d", want.lamp_index, got.lamp_index);
                mismatches++;
            end
            if (got.hold_ms !== want.hold_ms) begin
                $error("hold_ms: expected %0d, got %0d", want.hold_ms, got.hold_ms);
                mismatches++;
            end
            if (got.end_of_char !== want.end_of_char) begin
                $error("end_of_char: expected %0d, got %0d", want.end_of_char,
                       got.end_of_char);
                mismatches++;
            end
        endfunction

        function int owed();
            return owed_desc.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mcbs_char_if char_ch ();
    mcbs_desc_if desc_ch ();

    morse_code_blink_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_desc  (desc_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    blink_predictor pred = new();
    bit             hold_off_req = 1'b0;
    int             chars_sent   = 0;
    int             reg_writes   = 0;
    int             quiet_cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // All inputs known from time zero
    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        desc_ch.ready     = 1'b0;
    end

    // Monitor: input words first so a same-edge result still finds its entry
    initial begin : word_monitor
        bit          moved;
        t_blink_desc got;
        forever begin
            @(posedge i_clk);
            moved = 1'b0;
            if (char_ch.valid === 1'b1 && char_ch.ready === 1'b1) begin
                pred.char_taken(char_ch.char_code);
                moved = 1'b1;
            end
            if (desc_ch.valid === 1'b1 && desc_ch.ready === 1'b1) begin
                got.lamp_on     = desc_ch.lamp_on;
                got.lamp_index  = desc_ch.lamp_index;
                got.hold_ms     = desc_ch.hold_ms;
                got.end_of_char = desc_ch.end_of_char;
                pred.desc_seen(got);
                moved = 1'b1;
            end
            if (psel && penable && pready === 1'b1) moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Descriptor sink: bursts of random stalls, calm stretches, one long hold-off
    initial begin : desc_sink
        int  burst;
        int  roll;
        bit  calm;
        forever begin
            burst = $urandom_range(20, 80);
            calm  = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                @(negedge i_clk);
                roll = $urandom_range(0, 99);
                if (hold_off_req) begin
                    desc_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                    hold_off_req = 1'b0;
                end else if (calm || roll < 65) begin
                    desc_ch.ready <= 1'b1;
                end else if (roll < 95) begin
                    desc_ch.ready <= 1'b0;
                end else begin
                    desc_ch.ready <= 1'b0;
                    repeat ($urandom_range(5, 30)) @(negedge i_clk);
                end
            end
        end
    end

    // APB write: setup then access, committed on the access edge
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        pred.set_reg(idx, value);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one character word and hold it until taken
    task automatic send_char(logic [CHAR_W-1:0] c);
        @(negedge i_clk);
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        do @(posedge i_clk); while (char_ch.ready !== 1'b1);
        chars_sent++;
    endtask

    task automatic char_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            char_ch.valid     <= 1'b0;
            char_ch.char_code <= 8'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Idle the sender, wait out every owed descriptor, then let the block settle
    task automatic drain();
        char_gap(1);
        while (pred.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_gap(bit busy_mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (busy_mode || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_timing();
        int roll;
        logic [31:0] upper;
        roll  = $urandom_range(0, 9);
        upper = ($urandom_range(0, 3) == 0) ? {16'($urandom), 16'h0} : 32'h0;
        case (roll)
            0: return upper | 32'd0;
            1: return upper | 32'd1;
            2: return upper | 32'hFFFF;
            default: return upper | 32'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return CHR_UA + 8'($urandom_range(0, 25));
        if (roll < 45) return CHR_LA + 8'($urandom_range(0, 25));
        if (roll < 62) return CHR_0 + 8'($urandom_range(0, 9));
        if (roll < 72) return CHR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Main sequence
    initial begin : stimulus
        logic [CHAR_W-1:0] directed [$];
        logic [31:0]       lamp_val;
        bit                busy_mode;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: space, case and digit edges, codes next to the ranges
        directed = '{CHR_SPACE, CHR_UA, CHR_UZ, CHR_LA, CHR_LZ, CHR_0, CHR_9, 8'h45, 8'h54,
                     8'h51, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h1F,
                     8'h21, 8'hA0};
        foreach (directed[i]) begin
            send_char(directed[i]);
            char_gap(pick_gap(1'b0));
        end
        drain();

        // Extreme timing, top lamp, zero symbol gap, writes past the last register
        reg_write(REG_LAMP_SELECT, 32'd4);
        reg_write(REG_DOT_MS, 32'd1);
        reg_write(REG_DASH_MS, 32'hFFFF);
        reg_write(REG_GAP_SYMBOL_MS, 32'd0);
        reg_write(REG_GAP_LETTER_MS, 32'hFFFF);
        reg_write(REG_GAP_WORD_MS, 32'hFFFF_0001);
        reg_write(REG_SPARE_6, 32'h0000_0003);
        reg_write(REG_SPARE_7, 32'hFFFF_FFFF);
        send_char(8'h48);
        send_char(8'h35);
        send_char(CHR_SPACE);
        send_char(8'h79);
        drain();

        // Lamp numbers past the last lamp silence every character
        reg_write(REG_LAMP_SELECT, 32'd5);
        send_char(8'h4B);
        send_char(CHR_SPACE);
        drain();
        reg_write(REG_LAMP_SELECT, 32'hFFFF_FFFF);
        send_char(CHR_0);
        send_char(8'h7A);
        drain();

        // Random phases, each under fresh settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            lamp_val = ($urandom_range(0, 6) == 0) ? 32'($urandom_range(5, 7))
                                                   : 32'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) lamp_val |= {29'($urandom), 3'b000};
            reg_write(REG_LAMP_SELECT, ph == 0 ? 32'd0 : lamp_val);
            reg_write(REG_DOT_MS, pick_timing());
            reg_write(REG_DASH_MS, pick_timing());
            reg_write(REG_GAP_SYMBOL_MS, pick_timing());
            reg_write(REG_GAP_LETTER_MS, pick_timing());
            reg_write(REG_GAP_WORD_MS, pick_timing());
            // First phase: long sink hold-off while the sender keeps offering
            if (ph == 0) hold_off_req = 1'b1;
            busy_mode = 1'b0;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 25 == 0) busy_mode = (ph == 0 && n == 0) || ($urandom_range(0, 2) == 0);
                send_char(pick_char());
                char_gap(pick_gap(busy_mode));
            end
            drain();
        end

        $display("run: %0d character words, %0d descriptor words checked, %0d register writes",
                 chars_sent, pred.desc_checked, reg_writes);
        $display("settings covered reset values, timing extremes, zero lengths, silent lamps");
        if (pred.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
